// File: rtl/sha_pkg.sv
// Shared types, constants and round functions for the SHA-256 stream hasher.
package sha_pkg;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } msg_word_t;

    typedef struct packed {
        logic [31:0] digest_word0;
        logic [31:0] digest_word1;
        logic [31:0] digest_word2;
        logic [31:0] digest_word3;
        logic [31:0] digest_word4;
        logic [31:0] digest_word5;
        logic [31:0] digest_word6;
        logic [31:0] digest_word7;
    } digest_word_t;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam int BLOCK_WORDS = 16;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef logic [31:0] word_t;

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t init_hash(input logic [2:0] idx);
        case (idx)
            3'd0:    init_hash = 32'h6a09e667;
            3'd1:    init_hash = 32'hbb67ae85;
            3'd2:    init_hash = 32'h3c6ef372;
            3'd3:    init_hash = 32'ha54ff53a;
            3'd4:    init_hash = 32'h510e527f;
            3'd5:    init_hash = 32'h9b05688c;
            3'd6:    init_hash = 32'h1f83d9ab;
            default: init_hash = 32'h5be0cd19;
        endcase
    endfunction

    function automatic word_t round_k(input logic [5:0] t);
        case (t)
            6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;  default: round_k = 32'hc67178f2;
        endcase
    endfunction

endpackage

// File: rtl/sha_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module sha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/sha256_stream_hasher.sv
// Top level of the streaming SHA-256 hasher: byte intake, block RAM and round sequencer.
//
// Each accepted msg word carries one opcode. An absorb word adds one message byte; the 64th
// byte of a block also starts a compression that keeps msg_stall high through a read-ahead
// state (ST_PRE) for the block RAM, 64 rounds at one round per cycle (ST_COMP) and a state
// (ST_FOLD) that folds the working variables into the chain value. A finish word pads the
// message and runs one compression, or two when 56 or more bytes of the last block are
// buffered, then presents the digest as one word on the digest channel and starts the next
// message from the initial hash values.
// The sixteen message words of a block sit in a small RAM; words never written for the
// current block read as zero by way of a fill count, so no clearing pass is needed. The
// round loop is set by the single round datapath, and the schedule words for rounds 16 to 63
// come from a sixteen-word shift window. The digest sits in an output register, so a finish
// only waits when the previous digest has not yet been taken.
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         msg_valid,
    output logic         msg_stall,
    input  msg_word_t    msg,
    output logic         digest_valid,
    input  logic         digest_stall,
    output digest_word_t digest
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PRE  = 2'd1;
    localparam logic [1:0] ST_COMP = 2'd2;
    localparam logic [1:0] ST_FOLD = 2'd3;

    localparam int AW = $clog2(BLOCK_WORDS);

    logic [1:0]  state_reg, state_next;
    logic [5:0]  round_reg, round_next;
    logic [5:0]  nbytes_reg, nbytes_next;
    logic [AW:0] fill_reg, fill_next;
    logic [63:0] mbits_reg, mbits_next;
    logic [31:0] acc_reg, acc_next;
    logic        len_en_reg, len_en_next;
    logic        second_reg, second_next;
    logic        final_reg, final_next;
    logic        dvalid_reg, dvalid_next;

    word_t chain_reg [8];
    word_t chain_next [8];
    word_t v_reg [8];
    word_t v_next [8];
    word_t win_reg [BLOCK_WORDS];
    word_t win_next [BLOCK_WORDS];
    digest_word_t dout_reg, dout_next;

    logic          accept;
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    word_t         wr_data, rd_data;
    word_t         placed, wt, t1, t2, sum [8];

    assign accept       = msg_valid && !msg_stall;
    assign msg_stall    = (state_reg != ST_IDLE);
    assign digest_valid = dvalid_reg;
    assign digest       = dout_reg;

    sha_ram #(.WIDTH(32), .DEPTH(BLOCK_WORDS)) u_block_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Byte placed big-endian at its position inside the word being assembled.
    always_comb
    begin
        logic [7:0] b;
        b = (msg.op == OP_FINISH) ? PAD_BYTE : msg.data_byte;
        case (nbytes_reg[1:0])
            2'd0:    placed = acc_reg | {b, 24'h0};
            2'd1:    placed = acc_reg | {8'h0, b, 16'h0};
            2'd2:    placed = acc_reg | {16'h0, b, 8'h0};
            default: placed = acc_reg | {24'h0, b};
        endcase
    end

    assign wr_addr = nbytes_reg[5:2];
    assign wr_data = placed;
    assign wr_en   = accept && ((msg.op == OP_FINISH) || (nbytes_reg[1:0] == 2'd3));
    assign rd_addr = (state_reg == ST_COMP) ? (round_reg[AW-1:0] + 1'b1) : '0;

    // Message word for this round: block RAM, length words, zero fill or schedule.
    always_comb
    begin
        if (round_reg < 6'(BLOCK_WORDS))
        begin
            if ({1'b0, round_reg[AW-1:0]} < fill_reg)
                wt = rd_data;
            else if (len_en_reg && (round_reg[AW-1:0] == 4'd14))
                wt = mbits_reg[63:32];
            else if (len_en_reg && (round_reg[AW-1:0] == 4'd15))
                wt = mbits_reg[31:0];
            else
                wt = '0;
        end
        else
        begin
            wt = win_reg[0] + small_sigma0(win_reg[1]) + win_reg[9]
                 + small_sigma1(win_reg[14]);
        end
    end

    assign t1 = v_reg[7] + big_sigma1(v_reg[4])
                + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
                + round_k(round_reg) + wt;
    assign t2 = big_sigma0(v_reg[0])
                + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            sum[i] = chain_reg[i] + v_reg[i];
    end

    always_comb
    begin
        state_next  = state_reg;
        round_next  = round_reg;
        nbytes_next = nbytes_reg;
        fill_next   = fill_reg;
        mbits_next  = mbits_reg;
        acc_next    = acc_reg;
        len_en_next = len_en_reg;
        second_next = second_reg;
        final_next  = final_reg;
        dvalid_next = dvalid_reg && digest_stall;
        dout_next   = dout_reg;
        chain_next  = chain_reg;
        v_next      = v_reg;
        win_next    = win_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (msg.op == OP_ABSORB))
                begin
                    nbytes_next = nbytes_reg + 1'b1;
                    if (nbytes_reg[1:0] == 2'd3)
                    begin
                        acc_next  = '0;
                        fill_next = {1'b0, nbytes_reg[5:2]} + 1'b1;
                    end
                    else
                    begin
                        acc_next = placed;
                    end
                    if (nbytes_reg == 6'd63)
                    begin
                        mbits_next  = mbits_reg + 64'd512;
                        len_en_next = 1'b0;
                        second_next = 1'b0;
                        final_next  = 1'b0;
                        state_next  = ST_PRE;
                    end
                end
                else if (accept)
                begin
                    mbits_next  = mbits_reg + {55'h0, nbytes_reg, 3'b000};
                    fill_next   = {1'b0, nbytes_reg[5:2]} + 1'b1;
                    acc_next    = '0;
                    second_next = (nbytes_reg >= 6'd56);
                    len_en_next = (nbytes_reg < 6'd56);
                    final_next  = (nbytes_reg < 6'd56);
                    state_next  = ST_PRE;
                end
            end
            ST_PRE:
            begin
                round_next = '0;
                v_next     = chain_reg;
                state_next = ST_COMP;
            end
            ST_COMP:
            begin
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                for (int i = 0; i < BLOCK_WORDS - 1; i++)
                    win_next[i] = win_reg[i + 1];
                win_next[BLOCK_WORDS - 1] = wt;
                round_next = round_reg + 1'b1;
                if (round_reg == 6'd63)
                    state_next = ST_FOLD;
            end
            default:
            begin
                if (second_reg)
                begin
                    // Length did not fit; run one more block that carries only the length.
                    chain_next  = sum;
                    fill_next   = '0;
                    second_next = 1'b0;
                    len_en_next = 1'b1;
                    final_next  = 1'b1;
                    state_next  = ST_PRE;
                end
                else if (!final_reg)
                begin
                    chain_next = sum;
                    fill_next  = '0;
                    nbytes_next = '0;
                    state_next = ST_IDLE;
                end
                else if (!(dvalid_reg && digest_stall))
                begin
                    dvalid_next = 1'b1;
                    dout_next   = {sum[0], sum[1], sum[2], sum[3],
                                   sum[4], sum[5], sum[6], sum[7]};
                    for (int i = 0; i < 8; i++)
                        chain_next[i] = init_hash(3'(i));
                    fill_next   = '0;
                    nbytes_next = '0;
                    mbits_next  = '0;
                    len_en_next = 1'b0;
                    final_next  = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            round_reg  <= '0;
            nbytes_reg <= '0;
            fill_reg   <= '0;
            mbits_reg  <= '0;
            acc_reg    <= '0;
            len_en_reg <= 1'b0;
            second_reg <= 1'b0;
            final_reg  <= 1'b0;
            dvalid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= init_hash(3'(i));
        end
        else
        begin
            state_reg  <= state_next;
            round_reg  <= round_next;
            nbytes_reg <= nbytes_next;
            fill_reg   <= fill_next;
            mbits_reg  <= mbits_next;
            acc_reg    <= acc_next;
            len_en_reg <= len_en_next;
            second_reg <= second_next;
            final_reg  <= final_next;
            dvalid_reg <= dvalid_next;
            chain_reg  <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        win_reg  <= win_next;
        dout_reg <= dout_next;
    end

endmodule

// File: dv/tb.sv
// Self-checking testbench for the streaming SHA-256 hasher.
module tb;
    import sha_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         msg_valid;
    logic         msg_stall;
    logic         msg_stall_q;
    msg_word_t    msg;
    logic         digest_valid;
    logic         digest_stall;
    digest_word_t digest;

    sha256_stream_hasher u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .msg          (msg),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest)
    );

    // The clock runs with a period of 10 time units.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_OFF_CYCLES = 2000;

    // Words waiting to be driven, and digests waiting to come out.
    msg_word_t    pending_words[$];
    digest_word_t expected_digests[$];

    // Predictor state: chain value, block buffer, fill count and bit count.
    logic [31:0] hash_state[8];
    logic [31:0] block_buf[16];
    logic [5:0]  block_fill;
    logic [63:0] bit_count;

    int  error_count;
    int  words_sent;
    int  digests_seen;
    int  idle_cycles;
    bit  stimulus_done;
    bit  hold_request;

    localparam logic [31:0] ROUND_CONST[64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] START_HASH[8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Returns the predictor to the state of a fresh message.
    task automatic start_message();
        for (int i = 0; i < 8; i++)
        begin
            hash_state[i] = START_HASH[i];
        end
        for (int i = 0; i < 16; i++)
        begin
            block_buf[i] = '0;
        end
        block_fill = '0;
        bit_count  = '0;
    endtask

    // Folds the buffered block into the chain value and clears the buffer.
    task automatic fold_block();
        logic [31:0] sched[64];
        logic [31:0] v[8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int t = 0; t < 16; t++)
        begin
            sched[t] = block_buf[t];
        end
        for (int t = 16; t < 64; t++)
        begin
            sched[t] = sched[t-16] + sched[t-7]
                + (ror32(sched[t-15], 7) ^ ror32(sched[t-15], 18) ^ (sched[t-15] >> 3))
                + (ror32(sched[t-2], 17) ^ ror32(sched[t-2], 19) ^ (sched[t-2] >> 10));
        end
        for (int i = 0; i < 8; i++)
        begin
            v[i] = hash_state[i];
        end
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[t] + sched[t];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
        begin
            hash_state[i] = hash_state[i] + v[i];
            block_buf[i] = '0;
            block_buf[i+8] = '0;
        end
    endtask

    // Places one byte big-endian at the given position of the block buffer.
    task automatic place_byte(logic [5:0] pos, logic [7:0] b);
        block_buf[pos[5:2]] |= {24'h0, b} << (24 - 8 * pos[1:0]);
    endtask

    // Advances the predictor by one accepted word and queues any digest it yields.
    task automatic predict_hash(msg_word_t w);
        digest_word_t d;
        if (w.op == OP_ABSORB)
        begin
            place_byte(block_fill, w.data_byte);
            block_fill = block_fill + 6'd1;
            if (block_fill == 0)
            begin
                fold_block();
                bit_count = bit_count + 64'd512;
            end
        end
        else
        begin
            bit_count = bit_count + {55'h0, block_fill, 3'b000};
            place_byte(block_fill, PAD_BYTE);
            // When 56 or more bytes are buffered the length needs an extra block.
            if (block_fill >= 6'd56)
            begin
                fold_block();
            end
            block_buf[14] = bit_count[63:32];
            block_buf[15] = bit_count[31:0];
            fold_block();
            d = {hash_state[0], hash_state[1], hash_state[2], hash_state[3],
                 hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
            expected_digests.push_back(d);
            start_message();
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %08h expected %08h", $time, what, got, want);
        error_count++;
    endtask

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    task automatic queue_word(logic op, logic [7:0] b);
        msg_word_t w;
        w.op = op;
        w.data_byte = b;
        pending_words.push_back(w);
    endtask

    // Queues a message of n random bytes and its finish word.
    task automatic queue_message(int n);
        for (int i = 0; i < n; i++)
        begin
            queue_word(OP_ABSORB, 8'($urandom));
        end
        queue_word(OP_FINISH, 8'($urandom));
    endtask

    // Driver: offers words from the queue, with random gaps that are counted in
    // cycles. Valid is lowered only after an acceptance, never while stalled.
    int send_gap;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            msg_valid <= 1'b0;
            send_gap  <= 0;
        end
        else if (msg_valid && !msg_stall_q)
        begin
            // The word offered was taken at the last rising edge.
            if (send_gap == 0 && pending_words.size() > 0)
            begin
                msg <= pending_words.pop_front();
                send_gap <= gap_length();
            end
            else
            begin
                msg_valid <= 1'b0;
            end
        end
        else if (!msg_valid)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
            end
            else if (pending_words.size() > 0)
            begin
                msg       <= pending_words.pop_front();
                msg_valid <= 1'b1;
                send_gap  <= gap_length();
            end
        end
    end

    // Stall as seen at the last rising edge, so the driver knows whether its word went in.
    always @(posedge clk)
    begin
        msg_stall_q <= msg_stall;
    end

    // Receiver stall: random gaps, plus one long hold-off on request so that
    // the block fills up and stalls its input.
    int stall_left;
    int hold_left;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            digest_stall <= 1'b0;
            stall_left   <= 0;
            hold_left    <= 0;
        end
        else if (hold_request && hold_left == 0 && stall_left >= 0)
        begin
            hold_left    <= HOLD_OFF_CYCLES;
            digest_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            digest_stall <= (hold_left > 1);
        end
        else if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            digest_stall <= 1'b1;
        end
        else
        begin
            stall_left   <= gap_length();
            digest_stall <= 1'b0;
        end
    end

    // Monitor: predicts on accepted words and checks accepted digests.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((msg_valid && !msg_stall) || (digest_valid && !digest_stall))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (msg_valid && !msg_stall)
            begin
                predict_hash(msg);
                words_sent <= words_sent + 1;
            end
            if (digest_valid && !digest_stall)
            begin
                digests_seen <= digests_seen + 1;
                if (expected_digests.size() == 0)
                begin
                    $display("unexpected digest at %0t", $time);
                    error_count++;
                end
                else
                begin
                    check_digest(expected_digests.pop_front());
                end
            end
        end
    end

    task automatic check_digest(digest_word_t want);
        logic [255:0] got_bits;
        logic [255:0] want_bits;
        got_bits  = digest;
        want_bits = want;
        for (int i = 0; i < 8; i++)
        begin
            if (got_bits[255-32*i -: 32] !== want_bits[255-32*i -: 32])
            begin
                report_mismatch($sformatf("digest_word%0d", i),
                    got_bits[255-32*i -: 32], want_bits[255-32*i -: 32]);
            end
        end
    endtask

    // Watchdog: ends the run when nothing has been accepted for too long.
    always @(posedge clk)
    begin
        if (rst_n && idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout with %0d digests outstanding", expected_digests.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int len;
        int r;
        rst_n         = 1'b0;
        msg_valid     = 1'b0;
        msg           = '0;
        digest_stall  = 1'b0;
        msg_stall_q   = 1'b0;
        send_gap      = 0;
        stall_left    = 0;
        hold_left     = 0;
        hold_request  = 1'b0;
        error_count   = 0;
        words_sent    = 0;
        digests_seen  = 0;
        idle_cycles   = 0;
        stimulus_done = 1'b0;
        start_message();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: the empty message, a message of the extreme byte values,
        // a finish with a nonzero ignored byte, and a one-byte message.
        queue_word(OP_FINISH, 8'h00);
        queue_word(OP_ABSORB, 8'h00);
        queue_word(OP_ABSORB, 8'hff);
        queue_word(OP_ABSORB, 8'h5a);
        queue_word(OP_FINISH, 8'hff);
        queue_word(OP_FINISH, 8'ha5);
        queue_message(1);
        while (pending_words.size() > 0 || expected_digests.size() > 0)
        begin
            @(posedge clk);
        end

        // Length fit boundaries and block-aligned messages.
        queue_message(55);
        queue_message(56);
        queue_message(63);
        queue_message(64);
        queue_message(128);

        // Back-to-back short messages while the receiver holds off, so that
        // the digest register fills and the input stalls.
        for (int i = 0; i < 6; i++)
        begin
            queue_message(i);
        end
        @(negedge clk);
        hold_request = 1'b1;
        @(negedge clk);
        @(negedge clk);
        hold_request = 1'b0;

        // Random messages: mostly short, some around the block boundaries.
        while (words_sent + pending_words.size() < 800)
        begin
            r = $urandom_range(0, 9);
            if (r < 6)
            begin
                len = $urandom_range(0, 20);
            end
            else if (r < 9)
            begin
                len = $urandom_range(50, 70);
            end
            else
            begin
                len = $urandom_range(100, 200);
            end
            queue_message(len);
        end

        while (pending_words.size() > 0 || msg_valid || expected_digests.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);
        stimulus_done = 1'b1;

        $display("sent %0d message words, checked %0d digests", words_sent, digests_seen);
        $display("covered empty, short, boundary and multi-block messages under stalls");
        if (error_count == 0 && expected_digests.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
